/* sv/brb_pkg.sv */
// Shared types and constants for the chunked byte ring buffer.
// Used by the controller, the datapath and the top level; depends on nothing.
package brb_pkg;

   localparam int OP_W      = 2;
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 7;
   localparam int KIND_W    = 3;
   localparam int CNT_W     = 12;
   localparam int MAX_CHUNK = 64;
   localparam int CAP_FIELD_MAX = 4095;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      K_PUSH_OK  = 3'd0,
      K_PUSH_REJ = 3'd1,
      K_DATA     = 3'd2,
      K_READ_REJ = 3'd3,
      K_CLEARED  = 3'd4
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic accept;
      logic issue;
   } cmd_type;

   typedef struct packed {
      logic read_go;
      logic last_issue;
   } stat_type;

endpackage

/* sv/brb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the byte store.
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/brb_ctrl.sv */
// Controller state machine: accepts commands and sequences read streams.
// Depends on brb_pkg for the state, command and status types.
module brb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  brb_pkg::stat_type stat,
   output logic              busy,
   output brb_pkg::cmd_type  cmd
);
   import brb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && stat.read_go) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (stat.last_issue) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b0;
      cmd.accept = 1'b0;
      cmd.issue  = 1'b0;
      case (state_ff)
         ST_IDLE: cmd.accept = start;
         ST_READ: begin
            busy      = 1'b1;
            cmd.issue = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

endmodule

/* sv/brb_dpath.sv */
// Datapath: ring pointers, counts, chunk tracking, byte store and result registers.
// Depends on brb_pkg and brb_ram.
module brb_dpath #(
   parameter int SLOTS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  brb_pkg::cmd_type             cmd,
   output brb_pkg::stat_type            stat,
   input  logic [brb_pkg::OP_W-1:0]     req_op,
   input  logic [brb_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [brb_pkg::LEN_W-1:0]    req_chunk_len,
   input  logic                         req_chunk_first,
   input  logic                         csr_we,
   input  logic [brb_pkg::CNT_W-1:0]    csr_wdata,
   output logic                         rsp_valid,
   output logic [brb_pkg::KIND_W-1:0]   rsp_kind,
   output logic [brb_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_last,
   output logic [brb_pkg::CNT_W-1:0]    rsp_used_count,
   output logic [brb_pkg::CNT_W-1:0]    rsp_free_count
);
   import brb_pkg::*;

   localparam int DEPTH  = (SLOTS < CAP_FIELD_MAX + 1) ? SLOTS : CAP_FIELD_MAX + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(DEPTH - 1);

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] cursor_ff, cursor_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic              chunk_active_ff, chunk_active_in;
   logic              chunk_accepted_ff, chunk_accepted_in;
   logic [LEN_W-1:0]  chunk_left_ff, chunk_left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in;
   logic              last_ff, last_in;

   logic [LEN_W-1:0]  len;
   logic [CNT_W-1:0]  len_ext;
   logic [CNT_W-1:0]  room;
   logic              fits_read;
   logic [CNT_W:0]    ring;
   logic [CNT_W:0]    rp_sum;
   logic              wr_en;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_data;

   always_comb begin
      if (req_chunk_len == '0) begin
         len = LEN_W'(1);
      end else if (req_chunk_len > LEN_W'(MAX_CHUNK)) begin
         len = LEN_W'(MAX_CHUNK);
      end else begin
         len = req_chunk_len;
      end
   end

   assign len_ext   = CNT_W'(len);
   assign room      = cap_ff - used_ff;
   assign fits_read = len_ext <= used_ff;
   assign ring      = {1'b0, cap_ff} + (CNT_W + 1)'(1);
   assign rp_sum    = (CNT_W + 1)'(rp_ff) + {1'b0, len_ext};

   assign stat.read_go    = (req_op == OP_POP || req_op == OP_PEEK) && fits_read;
   assign stat.last_issue = remain_ff == LEN_W'(1);

   always_comb begin
      logic             act;
      logic             accd;
      logic             ok;
      logic [LEN_W-1:0] left;
      logic [CNT_W-1:0] sat;

      cap_in            = cap_ff;
      used_in           = used_ff;
      rp_in             = rp_ff;
      wp_in             = wp_ff;
      cursor_in         = cursor_ff;
      remain_in         = remain_ff;
      chunk_active_in   = chunk_active_ff;
      chunk_accepted_in = chunk_accepted_ff;
      chunk_left_in     = chunk_left_ff;
      rsp_valid_in      = 1'b0;
      kind_in           = kind_ff;
      last_in           = last_ff;
      wr_en             = 1'b0;
      rd_en             = 1'b0;
      act               = chunk_active_ff;
      accd              = chunk_accepted_ff;
      left              = chunk_left_ff;
      ok                = 1'b0;
      sat               = (csr_wdata > CAP_LIMIT) ? CAP_LIMIT : csr_wdata;

      if (csr_we) begin
         cap_in            = sat;
         used_in           = '0;
         rp_in             = '0;
         wp_in             = '0;
         chunk_active_in   = 1'b0;
         chunk_accepted_in = 1'b0;
         chunk_left_in     = '0;
      end else if (cmd.accept) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b1;
         case (req_op)
            OP_PUSH: begin
               if (req_chunk_first) begin
                  accd = len_ext <= room;
                  left = len;
                  act  = 1'b1;
               end
               if (!act) begin
                  kind_in = K_PUSH_REJ;
               end else begin
                  ok = accd && (used_ff < cap_ff);
                  if (ok) begin
                     wr_en   = 1'b1;
                     used_in = used_ff + CNT_W'(1);
                     wp_in   = (CNT_W'(wp_ff) == cap_ff) ? '0 : wp_ff + ADDR_W'(1);
                  end
                  left = left - LEN_W'(1);
                  if (left == '0) begin
                     act  = 1'b0;
                     accd = 1'b0;
                  end
                  chunk_active_in   = act;
                  chunk_accepted_in = accd;
                  chunk_left_in     = left;
                  kind_in           = ok ? K_PUSH_OK : K_PUSH_REJ;
               end
            end
            OP_CLEAR: begin
               used_in           = '0;
               rp_in             = '0;
               wp_in             = '0;
               chunk_active_in   = 1'b0;
               chunk_accepted_in = 1'b0;
               chunk_left_in     = '0;
               kind_in           = K_CLEARED;
            end
            default: begin
               if (!fits_read) begin
                  kind_in = K_READ_REJ;
               end else begin
                  rsp_valid_in = 1'b0;
                  cursor_in    = rp_ff;
                  remain_in    = len;
                  if (req_op == OP_POP) begin
                     used_in = used_ff - len_ext;
                     rp_in   = (rp_sum >= ring) ? ADDR_W'(rp_sum - ring) : ADDR_W'(rp_sum);
                  end
               end
            end
         endcase
      end else if (cmd.issue) begin
         rd_en        = 1'b1;
         cursor_in    = (CNT_W'(cursor_ff) == cap_ff) ? '0 : cursor_ff + ADDR_W'(1);
         remain_in    = remain_ff - LEN_W'(1);
         rsp_valid_in = 1'b1;
         kind_in      = K_DATA;
         last_in      = stat.last_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff            <= (CAP_LIMIT < CNT_W'(CAP_FIELD_MAX)) ? CAP_LIMIT
                                                                  : CNT_W'(CAP_FIELD_MAX);
         used_ff           <= '0;
         rp_ff             <= '0;
         wp_ff             <= '0;
         cursor_ff         <= '0;
         remain_ff         <= '0;
         chunk_active_ff   <= 1'b0;
         chunk_accepted_ff <= 1'b0;
         chunk_left_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         cap_ff            <= cap_in;
         used_ff           <= used_in;
         rp_ff             <= rp_in;
         wp_ff             <= wp_in;
         cursor_ff         <= cursor_in;
         remain_ff         <= remain_in;
         chunk_active_ff   <= chunk_active_in;
         chunk_accepted_ff <= chunk_accepted_in;
         chunk_left_ff     <= chunk_left_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   brb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_data_byte),
      .rd_en   (rd_en),
      .rd_addr (cursor_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_byte   = (kind_ff == K_DATA) ? rd_data : '0;
   assign rsp_last       = last_ff;
   assign rsp_used_count = used_ff;
   assign rsp_free_count = cap_ff - used_ff;

endmodule

/* sv/byte_ring_buffer_chunked.sv */
// Top level of the chunked byte ring buffer: controller, datapath and checks.
// Depends on brb_pkg, brb_ctrl and brb_dpath (which holds the brb_ram store).
//
// A byte FIFO of capacity+1 slots that keeps one slot open. Push, clear and
// rejected pop or peek commands may be issued every cycle while busy is low;
// their single result appears on the rsp_ ports in the next cycle. An
// accepted pop or peek of N bytes holds busy high while the byte store's
// one read port delivers its N bytes one byte per cycle. Results come with
// rsp_valid for exactly one cycle and cannot be stalled. The store needs no
// clearing pass after reset. Capacity writes are always ready and empty the
// buffer; issue them only while the block is idle.
module byte_ring_buffer_chunked #(
   parameter int SLOTS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [brb_pkg::OP_W-1:0]     req_op,
   input  logic [brb_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [brb_pkg::LEN_W-1:0]    req_chunk_len,
   input  logic                         req_chunk_first,
   output logic                         rsp_valid,
   output logic [brb_pkg::KIND_W-1:0]   rsp_kind,
   output logic [brb_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_last,
   output logic [brb_pkg::CNT_W-1:0]    rsp_used_count,
   output logic [brb_pkg::CNT_W-1:0]    rsp_free_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [brb_pkg::CNT_W-1:0]    csr_wdata
);
   import brb_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   brb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   brb_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .req_chunk_len   (req_chunk_len),
      .req_chunk_first (req_chunk_first),
      .csr_we          (csr_valid && csr_ready),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_used_count  (rsp_used_count),
      .rsp_free_count  (rsp_free_count)
   );

`ifndef SYNTHESIS
   a_data_from_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == K_DATA) |-> $past(busy))
      else $error("data word without a read stream");

   a_last_ends_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == K_DATA && rsp_last) |-> !busy)
      else $error("stream still busy after its last word");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != K_DATA) |-> rsp_last)
      else $error("non-data result not marked last");

   a_no_accept_while_streaming: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !cmd.accept)
      else $error("command accepted during a read stream");
`endif

endmodule
